[sv/rau_pkg.sv]
// ----------------------------------------------------------------------------
// rau_pkg
// Shared widths, operation and status codes, controller commands and the
// status bundle of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int NUM_W = 32;
    localparam int DEN_W = 32;
    // Magnitudes of numerators and denominators share one width.
    localparam int MAG_W = (NUM_W > DEN_W) ? NUM_W : DEN_W;
    localparam int PRD_W = 2 * MAG_W;
    localparam int SUM_W = PRD_W + 1;
    localparam int CNT_W = $clog2(SUM_W + 1);

    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_DIV = 4'd3;
    localparam logic [3:0] OP_EQ  = 4'd4;
    localparam logic [3:0] OP_NE  = 4'd5;
    localparam logic [3:0] OP_LT  = 4'd6;
    localparam logic [3:0] OP_LE  = 4'd7;
    localparam logic [3:0] OP_GT  = 4'd8;
    localparam logic [3:0] OP_GE  = 4'd9;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef enum logic [5:0] {
        C_NOP,
        C_LOAD,
        C_GCD_AB,
        C_GCD_BA,
        C_GCD_DD,
        C_GCD_GR,
        C_GCD_NEXT,
        C_SAVE_G1,
        C_SAVE_G2,
        C_DV_GCD,
        C_DV_AM_G1,
        C_DV_BD_G1_W,
        C_DV_BD_G1,
        C_DV_BM_G2,
        C_DV_AD_G2,
        C_DV_AD_G1,
        C_DV_S_G1,
        C_DV_S_G2,
        C_DV_BD_G2,
        C_MUL_PN,
        C_MUL_PD,
        C_MUL_T2,
        C_MUL_T1,
        C_MUL_DEN,
        C_MUL_C1,
        C_SUM,
        C_EMIT,
        C_CMP,
        C_FIN_ZERO,
        C_FIN_ERR,
        C_FIN_BLANK
    } t_cmd;

    typedef struct packed {
        logic op_bad;
        logic op_err;
        logic is_cmp;
        logic is_mul;
        logic zero_opnd;
        logic s_zero;
        logic gy_zero;
        logic div_busy;
        logic out_busy;
    } t_stat;

endpackage

[sv/rau_req_if.sv]
// ----------------------------------------------------------------------------
// rau_req_if
// Request channel: operation code and two fractions.
// ----------------------------------------------------------------------------
interface rau_req_if;
    logic                             valid;
    logic                             ready;
    logic [3:0]                       req_type;
    logic signed [rau_pkg::NUM_W-1:0] a_num;
    logic [rau_pkg::DEN_W-1:0]        a_den;
    logic signed [rau_pkg::NUM_W-1:0] b_num;
    logic [rau_pkg::DEN_W-1:0]        b_den;

    modport source (output valid, req_type, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, req_type, a_num, a_den, b_num, b_den, output ready);
endinterface

[sv/rau_res_if.sv]
// ----------------------------------------------------------------------------
// rau_res_if
// Result channel: reduced fraction, comparison outcome and status.
// ----------------------------------------------------------------------------
interface rau_res_if;
    logic                             valid;
    logic                             ready;
    logic signed [rau_pkg::NUM_W-1:0] res_num;
    logic [rau_pkg::DEN_W-1:0]        res_den;
    logic                             cmp_true;
    logic [1:0]                       status;

    modport source (output valid, res_num, res_den, cmp_true, status, input ready);
    modport sink   (input valid, res_num, res_den, cmp_true, status, output ready);
endinterface

[sv/rau_datapath.sv]
// ----------------------------------------------------------------------------
// rau_datapath
// Operand registers, one 32x32 multiplier, a shared restoring divider that
// yields one quotient bit per cycle, the signed sum, and the result register.
// ----------------------------------------------------------------------------
module rau_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rau_pkg::t_cmd                    i_cmd,
    output rau_pkg::t_stat                   o_stat,
    input  logic [3:0]                       i_req_type,
    input  logic signed [rau_pkg::NUM_W-1:0] i_a_num,
    input  logic [rau_pkg::DEN_W-1:0]        i_a_den,
    input  logic signed [rau_pkg::NUM_W-1:0] i_b_num,
    input  logic [rau_pkg::DEN_W-1:0]        i_b_den,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [rau_pkg::NUM_W-1:0] o_res_num,
    output logic [rau_pkg::DEN_W-1:0]        o_res_den,
    output logic                             o_cmp_true,
    output logic [1:0]                       o_status
);

    localparam int W  = rau_pkg::MAG_W;
    localparam int PW = rau_pkg::PRD_W;
    localparam int SW = rau_pkg::SUM_W;
    localparam int NW = rau_pkg::NUM_W;
    localparam int DW = rau_pkg::DEN_W;
    localparam int CW = rau_pkg::CNT_W;
    localparam logic [SW-1:0] LIM = SW'(1) << (NW - 1);

    typedef enum logic [2:0] {D_NONE, D_AM, D_BD, D_BM, D_AD, D_S} t_dst;

    logic [3:0]    r_op;
    logic          r_an, r_bn, r_neg;
    logic [W-1:0]  r_am, r_bm, r_ad, r_bd;
    logic [W-1:0]  r_gx, r_gy, r_g1, r_g2;
    logic [PW-1:0] r_x, r_y;
    logic [SW-1:0] r_s;
    logic [SW-1:0] r_dq;
    logic [W-1:0]  r_dr, r_dd;
    logic [CW-1:0] r_cnt;
    t_dst          r_dst;
    logic          r_ovalid;
    logic [NW-1:0] r_onum;
    logic [DW-1:0] r_oden;
    logic          r_ocmp;
    logic [1:0]    r_ost;

    logic [W-1:0]  w_amag, w_bmag, w_q;
    logic [W-1:0]  w_ma, w_mb;
    logic [PW-1:0] w_prod;
    logic [W:0]    w_rsh;
    logic          w_ge;
    logic [W-1:0]  w_rnx;
    logic [SW-1:0] w_dqnx;
    logic          w_dv_start, w_dv_wide;
    logic [W-1:0]  w_dv_num, w_dv_den;
    t_dst          w_dv_dst;
    logic [SW-1:0] w_x65, w_y65, w_diff, w_sum;
    logic          w_sneg;
    logic          w_lt, w_eq, w_xn, w_yn, w_true;
    logic          w_ovf;

    assign w_amag = i_a_num[NW-1] ? W'(~i_a_num) + W'(1) : W'(i_a_num);
    assign w_bmag = i_b_num[NW-1] ? W'(~i_b_num) + W'(1) : W'(i_b_num);
    assign w_q    = r_dq[W-1:0];

    always_comb begin
        w_ma = r_am;
        w_mb = r_bd;
        case (i_cmd)
            rau_pkg::C_MUL_PN:  begin w_ma = r_am; w_mb = r_bm; end
            rau_pkg::C_MUL_PD:  begin w_ma = r_ad; w_mb = r_bd; end
            rau_pkg::C_MUL_T2:  begin w_ma = r_bm; w_mb = r_ad; end
            rau_pkg::C_MUL_T1:  begin w_ma = r_am; w_mb = w_q;  end
            rau_pkg::C_MUL_DEN: begin w_ma = r_ad; w_mb = w_q;  end
            default:            begin w_ma = r_am; w_mb = r_bd; end
        endcase
    end
    assign w_prod = {{(PW-W){1'b0}}, w_ma} * {{(PW-W){1'b0}}, w_mb};

    // One restoring division step.
    assign w_rsh  = {r_dr, r_dq[SW-1]};
    assign w_ge   = w_rsh >= {1'b0, r_dd};
    assign w_rnx  = w_ge ? W'(w_rsh - {1'b0, r_dd}) : w_rsh[W-1:0];
    assign w_dqnx = {r_dq[SW-2:0], w_ge};

    always_comb begin
        w_dv_start = 1'b1;
        w_dv_wide  = 1'b0;
        w_dv_num   = r_gx;
        w_dv_den   = r_gy;
        w_dv_dst   = D_NONE;
        case (i_cmd)
            rau_pkg::C_DV_GCD:     begin w_dv_num = r_gx; w_dv_den = r_gy; end
            rau_pkg::C_DV_AM_G1:   begin w_dv_num = r_am; w_dv_den = r_g1; w_dv_dst = D_AM; end
            rau_pkg::C_DV_BD_G1_W: begin w_dv_num = r_bd; w_dv_den = r_g1; w_dv_dst = D_BD; end
            rau_pkg::C_DV_BD_G1:   begin w_dv_num = r_bd; w_dv_den = r_g1; end
            rau_pkg::C_DV_BM_G2:   begin w_dv_num = r_bm; w_dv_den = r_g2; w_dv_dst = D_BM; end
            rau_pkg::C_DV_AD_G2:   begin w_dv_num = r_ad; w_dv_den = r_g2; w_dv_dst = D_AD; end
            rau_pkg::C_DV_AD_G1:   begin w_dv_num = r_ad; w_dv_den = r_g1; w_dv_dst = D_AD; end
            rau_pkg::C_DV_S_G1:    begin w_dv_wide = 1'b1; w_dv_den = r_g1; end
            rau_pkg::C_DV_S_G2:    begin w_dv_wide = 1'b1; w_dv_den = r_g2; w_dv_dst = D_S; end
            rau_pkg::C_DV_BD_G2:   begin w_dv_num = r_bd; w_dv_den = r_g2; end
            default:               w_dv_start = 1'b0;
        endcase
    end

    // Signed sum of the two cross terms in sign-magnitude form.
    assign w_x65  = {1'b0, r_x};
    assign w_y65  = {1'b0, r_y};
    assign w_diff = w_x65 - w_y65;
    always_comb begin
        if (r_an == r_bn) begin
            w_sum  = w_x65 + w_y65;
            w_sneg = r_an;
        end else if (!w_diff[SW-1]) begin
            w_sum  = w_diff;
            w_sneg = r_an;
        end else begin
            w_sum  = w_y65 - w_x65;
            w_sneg = r_bn;
        end
    end

    // A zero magnitude carries no sign in the comparison.
    assign w_xn = r_an && (r_x != '0);
    assign w_yn = r_bn && (r_y != '0);
    always_comb begin
        if (w_xn != w_yn) begin
            w_lt = w_xn;
            w_eq = 1'b0;
        end else begin
            w_eq = r_x == r_y;
            w_lt = w_xn ? (r_y < r_x) : (r_x < r_y);
        end
        case (r_op)
            rau_pkg::OP_EQ: w_true = w_eq;
            rau_pkg::OP_NE: w_true = !w_eq;
            rau_pkg::OP_LT: w_true = w_lt;
            rau_pkg::OP_LE: w_true = w_lt || w_eq;
            rau_pkg::OP_GT: w_true = !w_lt && !w_eq;
            default:        w_true = !w_lt;
        endcase
    end

    assign w_ovf = (r_s > (r_neg ? LIM : LIM - SW'(1))) || (r_y[PW-1:DW] != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_dv_start) begin
                r_cnt <= w_dv_wide ? CW'(SW) : CW'(W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
            end
            if (i_cmd inside {rau_pkg::C_EMIT, rau_pkg::C_CMP, rau_pkg::C_FIN_ZERO,
                              rau_pkg::C_FIN_ERR, rau_pkg::C_FIN_BLANK}) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_dv_start) begin
            r_dq  <= w_dv_wide ? r_s : {w_dv_num, {(SW-W){1'b0}}};
            r_dr  <= '0;
            r_dd  <= w_dv_den;
            r_dst <= w_dv_dst;
        end else if (r_cnt != '0) begin
            r_dq <= w_dqnx;
            r_dr <= w_rnx;
            if (r_cnt == CW'(1)) begin
                case (r_dst)
                    D_AM:    r_am <= w_dqnx[W-1:0];
                    D_BD:    r_bd <= w_dqnx[W-1:0];
                    D_BM:    r_bm <= w_dqnx[W-1:0];
                    D_AD:    r_ad <= w_dqnx[W-1:0];
                    D_S:     r_s  <= w_dqnx;
                    default: ;
                endcase
            end
        end
        case (i_cmd)
            rau_pkg::C_LOAD: begin
                r_op <= i_req_type;
                r_an <= i_a_num[NW-1];
                r_bn <= i_b_num[NW-1] ^ (i_req_type == rau_pkg::OP_SUB);
                r_am <= w_amag;
                r_ad <= W'(i_a_den);
                if (i_req_type == rau_pkg::OP_DIV) begin
                    r_bm <= W'(i_b_den);
                    r_bd <= w_bmag;
                end else begin
                    r_bm <= w_bmag;
                    r_bd <= W'(i_b_den);
                end
            end
            rau_pkg::C_GCD_AB:   begin r_gx <= r_am; r_gy <= r_bd; end
            rau_pkg::C_GCD_BA:   begin r_gx <= r_bm; r_gy <= r_ad; end
            rau_pkg::C_GCD_DD:   begin r_gx <= r_ad; r_gy <= r_bd; end
            rau_pkg::C_GCD_GR:   begin r_gx <= r_g1; r_gy <= r_dr; end
            rau_pkg::C_GCD_NEXT: begin r_gx <= r_gy; r_gy <= r_dr; end
            rau_pkg::C_SAVE_G1:  r_g1 <= r_gx;
            rau_pkg::C_SAVE_G2:  r_g2 <= r_gx;
            rau_pkg::C_MUL_PN: begin
                r_s   <= {1'b0, w_prod};
                r_neg <= r_an ^ r_bn;
            end
            rau_pkg::C_MUL_PD, rau_pkg::C_MUL_T2, rau_pkg::C_MUL_DEN: r_y <= w_prod;
            rau_pkg::C_MUL_T1, rau_pkg::C_MUL_C1: r_x <= w_prod;
            rau_pkg::C_SUM: begin
                r_s   <= w_sum;
                r_neg <= w_sneg;
            end
            rau_pkg::C_EMIT: begin
                r_ocmp <= 1'b0;
                if (r_s == '0) begin
                    r_onum <= '0;
                    r_oden <= DW'(1);
                    r_ost  <= rau_pkg::ST_OK;
                end else if (w_ovf) begin
                    r_onum <= '0;
                    r_oden <= '0;
                    r_ost  <= rau_pkg::ST_OVF;
                end else begin
                    r_onum <= r_neg ? NW'(~r_s[NW-1:0]) + NW'(1) : r_s[NW-1:0];
                    r_oden <= r_y[DW-1:0];
                    r_ost  <= rau_pkg::ST_OK;
                end
            end
            rau_pkg::C_CMP: begin
                r_onum <= '0;
                r_oden <= '0;
                r_ocmp <= w_true;
                r_ost  <= rau_pkg::ST_OK;
            end
            rau_pkg::C_FIN_ZERO: begin
                r_onum <= '0;
                r_oden <= DW'(1);
                r_ocmp <= 1'b0;
                r_ost  <= rau_pkg::ST_OK;
            end
            rau_pkg::C_FIN_ERR: begin
                r_onum <= '0;
                r_oden <= '0;
                r_ocmp <= 1'b0;
                r_ost  <= rau_pkg::ST_ZERO;
            end
            rau_pkg::C_FIN_BLANK: begin
                r_onum <= '0;
                r_oden <= '0;
                r_ocmp <= 1'b0;
                r_ost  <= rau_pkg::ST_OK;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_stat.op_bad    = r_op > rau_pkg::OP_GE;
        o_stat.op_err    = (r_ad == '0) || (r_bd == '0) ||
                           ((r_op == rau_pkg::OP_DIV) && (r_bm == '0));
        o_stat.is_cmp    = r_op inside {[rau_pkg::OP_EQ:rau_pkg::OP_GE]};
        o_stat.is_mul    = r_op inside {rau_pkg::OP_MUL, rau_pkg::OP_DIV};
        o_stat.zero_opnd = (r_am == '0) || (r_bm == '0);
        o_stat.s_zero    = r_s == '0;
        o_stat.gy_zero   = r_gy == '0;
        o_stat.div_busy  = r_cnt != '0;
        o_stat.out_busy  = r_ovalid && !i_out_ready;
    end

    assign o_out_valid = r_ovalid;
    assign o_res_num   = r_onum;
    assign o_res_den   = r_oden;
    assign o_cmp_true  = r_ocmp;
    assign o_status    = r_ost;

endmodule

[sv/rau_ctrl.sv]
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: runs arithmetic via gcd, divide and multiply steps, compares via
// multiplies; shared gcd and divide-wait subroutines return to a saved state.
// ----------------------------------------------------------------------------
module rau_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rau_pkg::t_stat i_stat,
    output rau_pkg::t_cmd  o_cmd
);

    typedef enum logic [30:0] {
        S_IDLE  = 31'h00000001,
        S_CHECK = 31'h00000002,
        S_GCD   = 31'h00000004,
        S_GWAIT = 31'h00000008,
        S_DWAIT = 31'h00000010,
        S_FIN   = 31'h00000020,
        S_M1    = 31'h00000040,
        S_M2    = 31'h00000080,
        S_M3    = 31'h00000100,
        S_M4    = 31'h00000200,
        S_M5    = 31'h00000400,
        S_M6    = 31'h00000800,
        S_M7    = 31'h00001000,
        S_M8    = 31'h00002000,
        S_M9    = 31'h00004000,
        S_M10   = 31'h00008000,
        S_A1    = 31'h00010000,
        S_A2    = 31'h00020000,
        S_A3    = 31'h00040000,
        S_A4    = 31'h00080000,
        S_A5    = 31'h00100000,
        S_A6    = 31'h00200000,
        S_A7    = 31'h00400000,
        S_A8    = 31'h00800000,
        S_A9    = 31'h01000000,
        S_A10   = 31'h02000000,
        S_A11   = 31'h04000000,
        S_A12   = 31'h08000000,
        S_A13   = 31'h10000000,
        S_C1    = 31'h20000000,
        S_C2    = 31'h40000000
    } t_state;

    t_state        r_state, n_state;
    t_state        r_ret, n_ret;
    rau_pkg::t_cmd r_fin, n_fin;

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_fin      = r_fin;
        o_cmd      = rau_pkg::C_NOP;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd   = rau_pkg::C_LOAD;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.op_bad) begin
                    n_fin   = rau_pkg::C_FIN_BLANK;
                    n_state = S_FIN;
                end else if (i_stat.op_err) begin
                    n_fin   = rau_pkg::C_FIN_ERR;
                    n_state = S_FIN;
                end else if (i_stat.is_cmp) begin
                    n_state = S_C1;
                end else if (i_stat.is_mul) begin
                    if (i_stat.zero_opnd) begin
                        n_fin   = rau_pkg::C_FIN_ZERO;
                        n_state = S_FIN;
                    end else begin
                        n_state = S_M1;
                    end
                end else begin
                    n_state = S_A1;
                end
            end
            // Euclid loop: remainder of gx by gy until gy is zero.
            S_GCD: begin
                if (i_stat.gy_zero) begin
                    n_state = r_ret;
                end else begin
                    o_cmd   = rau_pkg::C_DV_GCD;
                    n_state = S_GWAIT;
                end
            end
            S_GWAIT: begin
                if (!i_stat.div_busy) begin
                    o_cmd   = rau_pkg::C_GCD_NEXT;
                    n_state = S_GCD;
                end
            end
            S_DWAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = r_ret;
                end
            end
            S_FIN: begin
                if (!i_stat.out_busy) begin
                    o_cmd   = r_fin;
                    n_state = S_IDLE;
                end
            end
            S_M1:  begin o_cmd = rau_pkg::C_GCD_AB;     n_ret = S_M2;  n_state = S_GCD;   end
            S_M2:  begin o_cmd = rau_pkg::C_SAVE_G1;    n_state = S_M3;                   end
            S_M3:  begin o_cmd = rau_pkg::C_GCD_BA;     n_ret = S_M4;  n_state = S_GCD;   end
            S_M4:  begin o_cmd = rau_pkg::C_SAVE_G2;    n_state = S_M5;                   end
            S_M5:  begin o_cmd = rau_pkg::C_DV_AM_G1;   n_ret = S_M6;  n_state = S_DWAIT; end
            S_M6:  begin o_cmd = rau_pkg::C_DV_BD_G1_W; n_ret = S_M7;  n_state = S_DWAIT; end
            S_M7:  begin o_cmd = rau_pkg::C_DV_BM_G2;   n_ret = S_M8;  n_state = S_DWAIT; end
            S_M8:  begin o_cmd = rau_pkg::C_DV_AD_G2;   n_ret = S_M9;  n_state = S_DWAIT; end
            S_M9:  begin o_cmd = rau_pkg::C_MUL_PN;     n_state = S_M10;                  end
            S_M10: begin
                o_cmd   = rau_pkg::C_MUL_PD;
                n_fin   = rau_pkg::C_EMIT;
                n_state = S_FIN;
            end
            S_A1:  begin o_cmd = rau_pkg::C_GCD_DD;     n_ret = S_A2;  n_state = S_GCD;   end
            S_A2:  begin o_cmd = rau_pkg::C_SAVE_G1;    n_state = S_A3;                   end
            S_A3:  begin o_cmd = rau_pkg::C_DV_AD_G1;   n_ret = S_A4;  n_state = S_DWAIT; end
            S_A4:  begin o_cmd = rau_pkg::C_MUL_T2;     n_state = S_A5;                   end
            S_A5:  begin o_cmd = rau_pkg::C_DV_BD_G1;   n_ret = S_A6;  n_state = S_DWAIT; end
            S_A6:  begin o_cmd = rau_pkg::C_MUL_T1;     n_state = S_A7;                   end
            S_A7:  begin o_cmd = rau_pkg::C_SUM;        n_state = S_A8;                   end
            S_A8: begin
                if (i_stat.s_zero) begin
                    n_fin   = rau_pkg::C_FIN_ZERO;
                    n_state = S_FIN;
                end else begin
                    o_cmd   = rau_pkg::C_DV_S_G1;
                    n_ret   = S_A9;
                    n_state = S_DWAIT;
                end
            end
            S_A9:  begin o_cmd = rau_pkg::C_GCD_GR;     n_ret = S_A10; n_state = S_GCD;   end
            S_A10: begin o_cmd = rau_pkg::C_SAVE_G2;    n_state = S_A11;                  end
            S_A11: begin o_cmd = rau_pkg::C_DV_S_G2;    n_ret = S_A12; n_state = S_DWAIT; end
            S_A12: begin o_cmd = rau_pkg::C_DV_BD_G2;   n_ret = S_A13; n_state = S_DWAIT; end
            S_A13: begin
                o_cmd   = rau_pkg::C_MUL_DEN;
                n_fin   = rau_pkg::C_EMIT;
                n_state = S_FIN;
            end
            S_C1:  begin o_cmd = rau_pkg::C_MUL_C1;     n_state = S_C2;                   end
            S_C2: begin
                o_cmd   = rau_pkg::C_MUL_T2;
                n_fin   = rau_pkg::C_CMP;
                n_state = S_FIN;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_fin   <= rau_pkg::C_FIN_BLANK;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_fin   <= n_fin;
        end
    end

endmodule

[sv/rational_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Adds, subtracts, multiplies, divides or compares two fractions and gives
// the result in lowest terms with a positive denominator.
//
//   Channel  Dir  Carries
//   i_req    in   req_type, a_num, a_den, b_num, b_den
//   o_res    out  res_num, res_den, cmp_true, status
//
// One request at a time. Multiply and divide run two gcds and four divides,
// add and subtract one gcd, a second gcd and five divides, all on the shared
// one-bit-per-cycle divider, which takes the full 65-bit sum when dividing it;
// each gcd runs one divide per Euclid step. Synchronous active-low reset
// returns the sequencer to idle. A result waits in the output register; the
// next request is taken meanwhile and stalls only at its own result.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rau_req_if.sink   i_req,
    rau_res_if.source o_res
);

    rau_pkg::t_cmd  w_cmd;
    rau_pkg::t_stat w_stat;
    logic           w_in_ready;

    rau_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    rau_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_req_type  (i_req.req_type),
        .i_a_num     (i_req.a_num),
        .i_a_den     (i_req.a_den),
        .i_b_num     (i_req.b_num),
        .i_b_den     (i_req.b_den),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_res_num   (o_res.res_num),
        .o_res_den   (o_res.res_den),
        .o_cmp_true  (o_res.cmp_true),
        .o_status    (o_res.status)
    );

    assign i_req.ready = w_in_ready;

`ifndef SYNTHESIS
    a_ovf_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status == rau_pkg::ST_OVF) |->
        (o_res.res_num == '0 && o_res.res_den == '0 && !o_res.cmp_true))
        else $error("overflow result carries nonzero fields");
    a_den_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status == rau_pkg::ST_OK && o_res.res_den == '0) |->
        (o_res.res_num == '0))
        else $error("nonzero numerator over zero denominator");
    a_cmp_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.cmp_true) |->
        (o_res.res_den == '0 && o_res.status == rau_pkg::ST_OK))
        else $error("comparison outcome set on an arithmetic result");
    a_busy_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.div_busy |-> !i_req.ready)
        else $error("request taken while the divider runs");
`endif

endmodule
